FILE: rtl/core/pddm_pkg.sv
`default_nettype none

package pddm_pkg;

  // Stick and drive fields
  localparam int unsigned IN_W  = 16;
  localparam int unsigned OUT_W = 16;

  // Cell chain: one root bit per cell, plus one CORDIC step in each rotating cell
  localparam int unsigned N_CELLS   = 24;
  localparam int unsigned SQ_W      = 2 * IN_W - 1;      // one square, x*x <= 2^30
  localparam int unsigned SQ_N_W    = 2 * IN_W + 16;     // radicand (x*x + y*y) << 16
  localparam int unsigned SQ_ROOT_W = SQ_N_W / 2;
  localparam int unsigned SQ_REM_W  = SQ_ROOT_W + 2;
  localparam int unsigned PRESHIFT  = 8;                 // CORDIC input scale x*256
  localparam int unsigned CW        = 28;                // CORDIC x/y datapath
  localparam int unsigned ZW        = 27;                // angle, degrees Q.16

  // Angle constants in degrees Q.16
  localparam int DEG_ONE = 65536;
  localparam logic signed [ZW-1:0] Z_DEG_45  = ZW'(45 * DEG_ONE);
  localparam logic signed [ZW-1:0] Z_DEG_90  = ZW'(90 * DEG_ONE);
  localparam logic signed [ZW-1:0] Z_DEG_180 = ZW'(180 * DEG_ONE);
  localparam logic signed [ZW-1:0] Z_DEG_360 = ZW'(360 * DEG_ONE);

  // Beats in flight between input accept and output: front, chain, mixer
  localparam int unsigned FRONT_STAGES = 2;
  localparam int unsigned MIX_STAGES   = 7;
  localparam int unsigned PIPE_DEPTH   = FRONT_STAGES + N_CELLS + MIX_STAGES;

  typedef struct packed {
    logic [SQ_N_W-1:0]    rad;
    logic [SQ_REM_W-1:0]  rem;
    logic [SQ_ROOT_W-1:0] root;
    logic [CW-1:0]        cx;
    logic [CW-1:0]        cy;
    logic [ZW-1:0]        z;
  } cell_t;

  typedef struct packed {
    logic [OUT_W-1:0] accel;
    logic [OUT_W-1:0] right;
    logic [OUT_W-1:0] left;
  } res_t;

  // atan(2^-i) in degrees Q.16, rounded to nearest
  function automatic logic [ZW-1:0] atan_q16(input int unsigned idx);
    logic [ZW-1:0] v;
    case (idx)
      0:       v = ZW'(2949120);
      1:       v = ZW'(1740967);
      2:       v = ZW'(919879);
      3:       v = ZW'(466945);
      4:       v = ZW'(234379);
      5:       v = ZW'(117304);
      6:       v = ZW'(58666);
      7:       v = ZW'(29335);
      8:       v = ZW'(14668);
      9:       v = ZW'(7334);
      10:      v = ZW'(3667);
      11:      v = ZW'(1833);
      12:      v = ZW'(917);
      13:      v = ZW'(458);
      14:      v = ZW'(229);
      15:      v = ZW'(115);
      16:      v = ZW'(57);
      17:      v = ZW'(29);
      18:      v = ZW'(14);
      19:      v = ZW'(7);
      20:      v = ZW'(4);
      21:      v = ZW'(2);
      22:      v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pddm_cell.sv
`default_nettype none

module pddm_cell #(
  parameter int unsigned IDX    = 0,
  parameter bit          ROTATE = 1'b1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  pddm_pkg::cell_t data_i,
  output logic            ready_o,
  output logic            valid_o,
  output pddm_pkg::cell_t data_o,
  input  logic            ready_i
);
  import pddm_pkg::*;

  localparam logic signed [ZW-1:0] ATAN_STEP = atan_q16(IDX);

  logic                  valid_q;
  cell_t                 data_q;
  cell_t                 data_d;
  logic                  en;

  logic [SQ_REM_W+1:0]   rem_sh;
  logic [SQ_REM_W+1:0]   trial;
  logic [SQ_REM_W+1:0]   rem_sub;
  logic                  ge;

  logic signed [CW-1:0]  cx;
  logic signed [CW-1:0]  cy;
  logic signed [CW-1:0]  dx;
  logic signed [CW-1:0]  dy;
  logic signed [ZW-1:0]  z;

  assign en      = ~valid_q | ready_i;
  assign ready_o = en;

  // Restoring square root: bring down two radicand bits, try subtracting 4q+1
  assign rem_sh  = {data_i.rem, data_i.rad[SQ_N_W-1 -: 2]};
  assign trial   = {2'b00, data_i.root, 2'b01};
  assign ge      = (rem_sh >= trial);
  assign rem_sub = rem_sh - trial;

  assign cx = $signed(data_i.cx);
  assign cy = $signed(data_i.cy);
  assign z  = $signed(data_i.z);
  assign dx = cy >>> IDX;
  assign dy = cx >>> IDX;

  always_comb begin
    data_d      = data_i;
    data_d.rad  = {data_i.rad[SQ_N_W-3:0], 2'b00};
    data_d.rem  = ge ? rem_sub[SQ_REM_W-1:0] : rem_sh[SQ_REM_W-1:0];
    data_d.root = {data_i.root[SQ_ROOT_W-2:0], ge};
    // Rotate toward the x axis; hold once the residual is exactly zero
    if (ROTATE && (cy != '0)) begin
      if (!cy[CW-1]) begin
        data_d.cx = cx + dx;
        data_d.cy = cy - dy;
        data_d.z  = z + ATAN_STEP;
      end else begin
        data_d.cx = cx - dx;
        data_d.cy = cy + dy;
        data_d.z  = z - ATAN_STEP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

FILE: rtl/core/pddm_mixer.sv
`default_nettype none

module pddm_mixer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic [pddm_pkg::SQ_ROOT_W-1:0]     mag_i,
  input  logic [pddm_pkg::ZW-1:0]            z_i,
  output logic                               ready_o,
  output logic                               valid_o,
  output pddm_pkg::res_t                     res_o,
  input  logic                               ready_i
);
  import pddm_pkg::*;

  localparam int unsigned MW      = SQ_ROOT_W;        // magnitude
  localparam int unsigned DM_W    = 24;               // |45 - m|, up to 135 deg Q.16
  localparam int unsigned PROD_W  = MW + DM_W;
  localparam int unsigned DM_FRAC = 15;               // divisor is 45 * 2^15
  localparam int unsigned A_W     = 32;
  localparam int unsigned RECIP_W = 27;
  localparam logic [RECIP_W-1:0] RECIP_45 = RECIP_W'(95443717);  // floor(2^32 / 45)
  localparam logic [A_W-1:0]     DIV_45   = A_W'(45);
  localparam int unsigned QA_W    = RECIP_W;
  localparam int unsigned VA_W    = QA_W + 1;
  localparam int unsigned VB_W    = 29;
  localparam logic signed [VB_W-1:0] DRIVE_ONE = VB_W'(1 << 24);
  localparam int unsigned RND_SH  = 12;
  localparam int unsigned SH_W    = VB_W + 1 - RND_SH;

  function automatic logic [OUT_W-1:0] to_q12(input logic signed [VB_W-1:0] v);
    logic signed [VB_W:0]   t;
    logic signed [SH_W-1:0] s;
    logic [OUT_W-1:0]       r;
    t = {v[VB_W-1], v} + (VB_W+1)'(1 << (RND_SH - 1));
    s = t[VB_W:RND_SH];
    if (s > SH_W'(32767)) begin
      r = 16'h7fff;
    end else if (s < -SH_W'(32768)) begin
      r = 16'h8000;
    end else begin
      r = s[OUT_W-1:0];
    end
    return r;
  endfunction

  logic [MIX_STAGES-1:0] vld_q;
  logic [MIX_STAGES-1:0] vld_in;
  logic [MIX_STAGES-1:0] en;

  always_comb begin
    en[MIX_STAGES-1] = ~vld_q[MIX_STAGES-1] | ready_i;
    for (int k = MIX_STAGES - 2; k >= 0; k--) begin
      en[k] = ~vld_q[k] | en[k+1];
    end
  end

  assign vld_in  = {vld_q[MIX_STAGES-2:0], valid_i};
  assign ready_o = en[0];
  assign valid_o = vld_q[MIX_STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < MIX_STAGES; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  // Stage 0: wrap the angle into [-180, 180)
  logic signed [ZW-1:0] z_in;
  logic signed [ZW-1:0] th_d;
  logic signed [ZW-1:0] s0_th_q;
  logic [MW-1:0]        s0_mag_q;

  assign z_in = $signed(z_i);

  always_comb begin
    if (z_in >= Z_DEG_180) begin
      th_d = z_in - Z_DEG_360;
    end else if (z_in < -Z_DEG_180) begin
      th_d = z_in + Z_DEG_360;
    end else begin
      th_d = z_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s0_th_q  <= th_d;
      s0_mag_q <= mag_i;
    end
  end

  // Stage 1: residue modulo 90 with the sign of the angle, quadrant signs
  logic signed [ZW-1:0] m_d;
  logic signed [ZW-1:0] dm_d;
  logic [ZW-1:0]        dm_neg_val;
  logic [MW-1:0]        s1_mag_q;
  logic [DM_W-1:0]      s1_dm_abs_q;
  logic                 s1_dm_neg_q;
  logic                 s1_ln_q;
  logic                 s1_rn_q;

  always_comb begin
    if (s0_th_q >= Z_DEG_90) begin
      m_d = s0_th_q - Z_DEG_90;
    end else if (s0_th_q > -Z_DEG_90) begin
      m_d = s0_th_q;
    end else if (s0_th_q == -Z_DEG_180) begin
      m_d = '0;
    end else begin
      m_d = s0_th_q + Z_DEG_90;
    end
    dm_d       = Z_DEG_45 - m_d;
    dm_neg_val = -dm_d;
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_mag_q    <= s0_mag_q;
      s1_dm_neg_q <= dm_d[ZW-1];
      s1_dm_abs_q <= dm_d[ZW-1] ? dm_neg_val[DM_W-1:0] : dm_d[DM_W-1:0];
      s1_ln_q     <= s0_th_q[ZW-1];
      s1_rn_q     <= (s0_th_q < -Z_DEG_90) || (s0_th_q >= Z_DEG_90);
    end
  end

  // Stage 2: magnitude times |45 - m|
  logic [MW-1:0]     s2_mag_q;
  logic [PROD_W-1:0] s2_prod_q;
  logic              s2_dm_neg_q;
  logic              s2_ln_q;
  logic              s2_rn_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_mag_q    <= s1_mag_q;
      s2_prod_q   <= PROD_W'(s1_mag_q) * PROD_W'(s1_dm_abs_q);
      s2_dm_neg_q <= s1_dm_neg_q;
      s2_ln_q     <= s1_ln_q;
      s2_rn_q     <= s1_rn_q;
    end
  end

  // Stage 3: drop 2^15, estimate the quotient by 45 with the reciprocal
  logic [A_W-1:0]         a_d;
  logic [A_W+RECIP_W-1:0] pk_d;
  logic [MW-1:0]          s3_mag_q;
  logic [A_W-1:0]         s3_a_q;
  logic [QA_W-1:0]        s3_q0_q;
  logic                   s3_dm_neg_q;
  logic                   s3_ln_q;
  logic                   s3_rn_q;

  assign a_d  = s2_prod_q[DM_FRAC +: A_W];
  assign pk_d = (A_W+RECIP_W)'(a_d) * (A_W+RECIP_W)'(RECIP_45);

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s3_mag_q    <= s2_mag_q;
      s3_a_q      <= a_d;
      s3_q0_q     <= pk_d[A_W+RECIP_W-1:A_W];
      s3_dm_neg_q <= s2_dm_neg_q;
      s3_ln_q     <= s2_ln_q;
      s3_rn_q     <= s2_rn_q;
    end
  end

  // Stage 4: correct the estimate (low by at most one), apply the sign
  logic [A_W-1:0]         rem_d;
  logic [QA_W-1:0]        qabs_d;
  logic signed [VA_W-1:0] va_d;
  logic [MW-1:0]          s4_mag_q;
  logic signed [VA_W-1:0] s4_va_q;
  logic                   s4_ln_q;
  logic                   s4_rn_q;

  always_comb begin
    rem_d  = s3_a_q - A_W'(s3_q0_q) * DIV_45;
    qabs_d = s3_q0_q + QA_W'(rem_d >= DIV_45);
    va_d   = s3_dm_neg_q ? -$signed({1'b0, qabs_d}) : $signed({1'b0, qabs_d});
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s4_mag_q <= s3_mag_q;
      s4_va_q  <= va_d;
      s4_ln_q  <= s3_ln_q;
      s4_rn_q  <= s3_rn_q;
    end
  end

  // Stage 5: v_b = min(1.0, 2r + v_a, 2r - v_a)
  logic signed [VB_W-1:0] two_r;
  logic signed [VB_W-1:0] va_x;
  logic signed [VB_W-1:0] sum_p;
  logic signed [VB_W-1:0] sum_m;
  logic signed [VB_W-1:0] vb_d;
  logic signed [VB_W-1:0] s5_va_q;
  logic signed [VB_W-1:0] s5_vb_q;
  logic                   s5_ln_q;
  logic                   s5_rn_q;

  always_comb begin
    two_r = $signed({{(VB_W-MW-2){1'b0}}, s4_mag_q, 2'b00});
    va_x  = {{(VB_W-VA_W){s4_va_q[VA_W-1]}}, s4_va_q};
    sum_p = two_r + va_x;
    sum_m = two_r - va_x;
    vb_d  = DRIVE_ONE;
    if (sum_p < vb_d) begin
      vb_d = sum_p;
    end
    if (sum_m < vb_d) begin
      vb_d = sum_m;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s5_va_q <= va_x;
      s5_vb_q <= vb_d;
      s5_ln_q <= s4_ln_q;
      s5_rn_q <= s4_rn_q;
    end
  end

  // Stage 6: quadrant signs, round to Q4.12, saturate
  logic signed [VB_W-1:0] left_d;
  logic signed [VB_W-1:0] right_d;
  logic signed [VB_W-1:0] accel_d;
  res_t                   res_q;

  assign left_d  = s5_ln_q ? -s5_va_q : s5_va_q;
  assign right_d = s5_rn_q ? -s5_vb_q : s5_vb_q;
  assign accel_d = s5_va_q + s5_vb_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      res_q.left  <= to_q12(left_d);
      res_q.right <= to_q12(right_d);
      res_q.accel <= to_q12(accel_d);
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

FILE: rtl/core/polar_differential_drive_mixer_core.sv
// Polar differential-drive mixer.
// Turns a two-axis stick sample into left/right track commands and an
// acceleration command, all signed Q4.12 with saturation.
// Slave channel (s_axis_*): one stick sample per beat. Master channel
// (m_axis_*): one result beat per accepted sample, in order.
// Throughput: one beat per cycle, sustained while the receiver keeps up.
// The accepting edge loads the first of 33 registered stages: the chain of
// 24 cells (one square-root bit per cell, and a CORDIC vectoring step in the
// first CORDIC_STAGES cells) plus 2 front stages (squares and setup, radicand)
// and 7 mixer stages (wrap, mod 90, multiply, reciprocal divide by 45, min,
// round); m_axis_tvalid comes from the last of them.
// Every stage holds its own valid bit and advances into an empty or moving
// successor, so when m_axis_tready is low the output holds its beat and the
// upstream stages keep filling their bubbles; s_axis_tready drops only once
// all 33 stages are full.
// Reset clears every valid bit; no result is shown until a new sample enters.
// CORDIC_STAGES (8..24) sets how many cells run a vectoring step; the rest
// only pass the angle through.
`default_nettype none

module polar_differential_drive_mixer_core #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] stick_left, [31:16] stick_right
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // [15:0] left_drive, [31:16] right_drive,
                                      // [47:32] accel_drive
);
  import pddm_pkg::*;

  // Front stage 0: squares and CORDIC setup
  logic signed [IN_W-1:0]   x_in;
  logic signed [IN_W-1:0]   y_in;
  logic signed [2*IN_W-1:0] sq_x;
  logic signed [2*IN_W-1:0] sq_y;
  logic signed [CW-1:0]     x_sc;
  logic signed [CW-1:0]     y_sc;
  logic signed [CW-1:0]     cx_d;
  logic signed [CW-1:0]     cy_d;
  logic signed [ZW-1:0]     z_d;

  logic                     f0_vld_q;
  logic                     f0_en;
  logic [SQ_W-1:0]          f0_sq_x_q;
  logic [SQ_W-1:0]          f0_sq_y_q;
  logic [CW-1:0]            f0_cx_q;
  logic [CW-1:0]            f0_cy_q;
  logic [ZW-1:0]            f0_z_q;

  logic                     f1_vld_q;
  logic                     f1_en;
  cell_t                    f1_data_q;
  logic [SQ_W:0]            sq_sum;

  logic [N_CELLS:0]         cell_vld;
  logic [N_CELLS:0]         cell_rdy;
  cell_t                    cell_data [N_CELLS+1];

  logic                     mix_rdy;
  res_t                     mix_res;

  assign x_in = $signed(s_axis_tdata[IN_W-1:0]);
  assign y_in = $signed(s_axis_tdata[2*IN_W-1:IN_W]);
  assign sq_x = x_in * x_in;
  assign sq_y = y_in * y_in;
  assign x_sc = {{(CW-IN_W-PRESHIFT){x_in[IN_W-1]}}, x_in, {PRESHIFT{1'b0}}};
  assign y_sc = {{(CW-IN_W-PRESHIFT){y_in[IN_W-1]}}, y_in, {PRESHIFT{1'b0}}};

  // On the vertical axis the angle is exact: park the residual at zero so
  // no cell rotates. In the left half plane mirror the vector and start
  // from +-180.
  always_comb begin
    if (x_in == '0) begin
      cx_d = x_sc;
      cy_d = '0;
      if (y_in > 0) begin
        z_d = Z_DEG_90;
      end else if (y_in < 0) begin
        z_d = -Z_DEG_90;
      end else begin
        z_d = '0;
      end
    end else if (x_in < 0) begin
      cx_d = -x_sc;
      cy_d = -y_sc;
      z_d  = y_in[IN_W-1] ? -Z_DEG_180 : Z_DEG_180;
    end else begin
      cx_d = x_sc;
      cy_d = y_sc;
      z_d  = '0;
    end
  end

  assign f0_en         = ~f0_vld_q | f1_en;
  assign s_axis_tready = f0_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f0_vld_q <= 1'b0;
    end else if (f0_en) begin
      f0_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f0_en) begin
      f0_sq_x_q <= sq_x[SQ_W-1:0];
      f0_sq_y_q <= sq_y[SQ_W-1:0];
      f0_cx_q   <= cx_d;
      f0_cy_q   <= cy_d;
      f0_z_q    <= z_d;
    end
  end

  // Front stage 1: form the radicand and load the first cell's beat
  assign sq_sum = {1'b0, f0_sq_x_q} + {1'b0, f0_sq_y_q};
  assign f1_en  = ~f1_vld_q | cell_rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
    end else if (f1_en) begin
      f1_vld_q <= f0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f1_en) begin
      f1_data_q.rad  <= {sq_sum, {(SQ_N_W-SQ_W-1){1'b0}}};
      f1_data_q.rem  <= '0;
      f1_data_q.root <= '0;
      f1_data_q.cx   <= f0_cx_q;
      f1_data_q.cy   <= f0_cy_q;
      f1_data_q.z    <= f0_z_q;
    end
  end

  assign cell_vld[0]  = f1_vld_q;
  assign cell_data[0] = f1_data_q;

  // Cell chain: each cell adds one root bit and, up to CORDIC_STAGES, one
  // vectoring step
  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    pddm_cell #(
      .IDX    (i),
      .ROTATE (i < CORDIC_STAGES)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cell_vld[i]),
      .data_i  (cell_data[i]),
      .ready_o (cell_rdy[i]),
      .valid_o (cell_vld[i+1]),
      .data_o  (cell_data[i+1]),
      .ready_i (cell_rdy[i+1])
    );
  end

  assign cell_rdy[N_CELLS] = mix_rdy;

  // Mixer: angle wrap, v_a and v_b, quadrant signs, Q4.12 output register
  pddm_mixer u_mixer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cell_vld[N_CELLS]),
    .mag_i   (cell_data[N_CELLS].root),
    .z_i     (cell_data[N_CELLS].z),
    .ready_o (mix_rdy),
    .valid_o (m_axis_tvalid),
    .res_o   (mix_res),
    .ready_i (m_axis_tready)
  );

  assign m_axis_tdata = mix_res;

endmodule

`default_nettype wire

FILE: rtl/core/pddm_checker.sv
`default_nettype none

module pddm_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata
);
  import pddm_pkg::*;

  localparam int unsigned CNT_W = $clog2(PIPE_DEPTH + 1);

  logic             in_beat;
  logic             out_beat;
  logic [CNT_W-1:0] inflight_q;
  logic [CNT_W-1:0] inflight_d;

  assign in_beat  = s_axis_tvalid & s_axis_tready;
  assign out_beat = m_axis_tvalid & m_axis_tready;

  always_comb begin
    inflight_d = inflight_q;
    if (in_beat && !out_beat) begin
      inflight_d = inflight_q + 1'b1;
    end else if (!in_beat && out_beat) begin
      inflight_d = inflight_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // Never more beats in flight than the pipeline has stages
  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= CNT_W'(PIPE_DEPTH))
    else $error("more samples accepted than the pipeline can hold");

  // No result without an accepted sample behind it
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> inflight_q != '0)
    else $error("result beat without a pending sample");

  // v_a + v_b never goes below zero
  a_accel_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[47])
    else $error("negative acceleration command");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

endmodule

bind polar_differential_drive_mixer_core pddm_checker u_pddm_checker (.*);

`default_nettype wire

FILE: verif/pddm_drive_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the mixer, predicts every result beat from the
// accepted stick beat and compares the two in order.
module pddm_drive_checker #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  input  logic              s_tready_i,
  input  logic [31:0]       s_tdata_i,   // [15:0] stick_left, [31:16] stick_right
  input  logic              m_tvalid_i,
  input  logic              m_tready_i,
  input  logic [47:0]       m_tdata_i,   // [15:0] left, [31:16] right, [47:32] accel
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);
  import pddm_pkg::*;

  localparam longint DEG_Q16    = 65536;
  localparam int     ATAN_STEPS = 24;
  localparam real    PI         = 3.14159265358979323846;

  longint      atan_deg_tbl [ATAN_STEPS];
  res_t        drive_q [$];
  res_t        want;
  res_t        got;
  int unsigned fails = 0;

  // atan(2^-k) in degrees Q.16, rounded to nearest
  initial begin
    for (int k = 0; k < ATAN_STEPS; k++) begin
      atan_deg_tbl[k] = longint'($floor($atan(2.0 ** (-k)) * 180.0 / PI * 65536.0 + 0.5));
    end
  end

  function automatic longint floor_root(input longint n);
    longint r;
    longint t;
    r = 0;
    for (int b = 24; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic longint stick_angle(input longint x, input longint y);
    longint cx;
    longint cy;
    longint z;
    longint dx;
    longint dy;
    if (x == 0) begin
      if (y > 0) return 90 * DEG_Q16;
      else if (y < 0) return -90 * DEG_Q16;
      else return 0;
    end
    z  = 0;
    cx = x * 256;
    cy = y * 256;
    // fold the left half plane onto the right one
    if (cx < 0) begin
      cx = -cx;
      cy = -cy;
      z  = (y >= 0) ? 180 * DEG_Q16 : -180 * DEG_Q16;
    end
    for (int i = 0; i < int'(CORDIC_STEPS) && i < ATAN_STEPS; i++) begin
      if (cy != 0) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy > 0) begin
          cx = cx + dx;
          cy = cy - dy;
          z  = z + atan_deg_tbl[i];
        end else begin
          cx = cx - dx;
          cy = cy + dy;
          z  = z - atan_deg_tbl[i];
        end
      end
    end
    if (z >= 180 * DEG_Q16) z = z - 360 * DEG_Q16;
    else if (z < -180 * DEG_Q16) z = z + 360 * DEG_Q16;
    return z;
  endfunction

  function automatic logic [OUT_W-1:0] sat_q12(input longint v);
    longint q;
    q = (v + 2048) >>> 12;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[OUT_W-1:0];
  endfunction

  function automatic res_t mix_stick(input logic [31:0] data);
    longint x;
    longint y;
    longint mag;
    longint th;
    longint m;
    longint va;
    longint vb;
    longint two_r;
    longint lt;
    longint rt;
    res_t   r;
    x     = $signed(data[15:0]);
    y     = $signed(data[31:16]);
    mag   = floor_root((x * x + y * y) << 16);
    th    = stick_angle(x, y);
    m     = th % (90 * DEG_Q16);       // keeps the sign of the angle
    va    = (mag * (45 * DEG_Q16 - m)) / (45 * 32768);
    two_r = 4 * mag;
    vb    = longint'(1) << 24;
    if (two_r + va < vb) vb = two_r + va;
    if (two_r - va < vb) vb = two_r - va;
    if (th < -90 * DEG_Q16) begin
      lt = -va;
      rt = -vb;
    end else if (th < 0) begin
      lt = -va;
      rt = vb;
    end else if (th < 90 * DEG_Q16) begin
      lt = va;
      rt = vb;
    end else begin
      lt = va;
      rt = -vb;
    end
    r.left  = sat_q12(lt);
    r.right = sat_q12(rt);
    r.accel = sat_q12(va + vb);
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_i) drive_q.push_back(mix_stick(s_tdata_i));
      if (m_tvalid_i && m_tready_i) begin
        got = res_t'(m_tdata_i);
        if (drive_q.size() == 0) begin
          fails++;
          if (fails <= 50)
            $display("%0t: unexpected result beat left=%0d right=%0d accel=%0d", $time,
                     $signed(got.left), $signed(got.right), $signed(got.accel));
        end else begin
          want = drive_q.pop_front();
          if (got.left !== want.left || got.right !== want.right ||
              got.accel !== want.accel) begin
            fails++;
            // keep the log short on a broken build
            if (fails <= 50)
              $display("%0t: mismatch expected l=%0d r=%0d a=%0d actual l=%0d r=%0d a=%0d",
                       $time, $signed(want.left), $signed(want.right),
                       $signed(want.accel), $signed(got.left), $signed(got.right),
                       $signed(got.accel));
          end
        end
      end
      pending_o    <= drive_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the polar mixer. The checker beside the block
// does all prediction and comparison; this module only feeds stick beats,
// throttles the result side and reports the outcome.
module testbench;

  localparam int unsigned CORDIC_STEPS = 16;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [47:0] m_tdata;

  logic        s_fire    = 1'b0;  // stick beat taken at the last rising edge
  logic        idle_on   = 1'b0;  // random bursts of idling on both sides
  logic        hold_go   = 1'b0;  // ask the receiver for one long hold-off
  logic        hold_done = 1'b0;

  int unsigned fail_count;
  int unsigned pending;

  polar_differential_drive_mixer_core #(
    .CORDIC_STAGES (CORDIC_STEPS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),    // [15:0] stick_left, [31:16] stick_right
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)     // [15:0] left, [31:16] right, [47:32] accel
  );

  pddm_drive_checker #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Capture the handshake before the block updates at the same edge.
  always @(posedge clk_i) begin
    s_fire <= s_tvalid && s_tready;
  end

  // Bound the run well beyond the slowest legal schedule.
  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Result side: random stalls, one long hold-off on request, plain
  // streaming once idling is switched off.
  initial begin
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_go && !hold_done) begin
        // hold long enough for the whole pipeline to back up
        m_tready = 1'b0;
        repeat (150) @(negedge clk_i);
        hold_done = 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk_i);
      end else begin
        m_tready = 1'b1;
        @(negedge clk_i);
      end
    end
  end

  // Offer one stick beat, after an optional idle burst; return at the
  // falling edge after it was taken.
  task automatic send_stick(input logic [15:0] x, input logic [15:0] y);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    s_tvalid = 1'b1;
    s_tdata  = {y, x};
    do @(negedge clk_i); while (!s_fire);
    s_tvalid = 1'b0;
  endtask

  function automatic logic [15:0] edge_axis();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h8001;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      4:       return 16'h0001;
      default: return 16'h7FFF;
    endcase
  endfunction

  // Mostly full-range samples, plus small sticks, axes, diagonals and
  // extreme corners where the angle path has exact cases.
  task automatic send_random_stick();
    logic [15:0] x;
    logic [15:0] y;
    int          a;
    int          b;
    x = 16'($urandom);
    y = 16'($urandom);
    case ($urandom_range(0, 9))
      5, 6: begin
        a = $urandom_range(0, 600);
        b = $urandom_range(0, 600);
        x = 16'(a - 300);
        y = 16'(b - 300);
      end
      7: begin
        if ($urandom_range(0, 1) == 0) x = '0;
        else y = '0;
      end
      8: y = ($urandom_range(0, 1) == 0) ? x : -x;
      9: begin
        x = edge_axis();
        y = edge_axis();
      end
      default: ;
    endcase
    send_stick(x, y);
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    // Drop reset with a real falling edge so the asynchronous clear acts
    // before the first rising clock edge.
    #1 rst_ni = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: zero stick, extremes, axes, diagonals, the wrap at 180.
    idle_on = 1'b1;
    send_stick(16'h0000, 16'h0000);
    send_stick(16'h7FFF, 16'h0000);
    send_stick(16'h8000, 16'h0000);
    send_stick(16'h0000, 16'h7FFF);
    send_stick(16'h0000, 16'h8000);
    send_stick(16'h0000, 16'h0001);
    send_stick(16'h0000, 16'hFFFF);
    send_stick(16'h7FFF, 16'h7FFF);
    send_stick(16'h8000, 16'h8000);
    send_stick(16'h8000, 16'h7FFF);
    send_stick(16'h7FFF, 16'h8000);
    send_stick(16'hFFFF, 16'h0000);  // negative x, zero y: lands on -180
    send_stick(16'hFFFF, 16'hFFFF);
    send_stick(16'hFFFF, 16'h0001);
    send_stick(16'h0001, 16'h0001);
    send_stick(16'h0001, 16'hFFFF);
    send_stick(16'h8000, 16'hFFFF);
    send_stick(16'h0064, 16'hFF9C);
    send_stick(16'h3039, 16'hE57B);
    send_stick(16'hFED4, 16'h0005);
    send_stick(16'hAAAA, 16'h5555);

    repeat (200) send_random_stick();

    // Back-pressure: keep offering while the receiver holds off, so the
    // pipeline fills and the input stalls.
    hold_go = 1'b1;
    idle_on = 1'b0;
    repeat (80) send_random_stick();
    while (!hold_done) @(negedge clk_i);

    // Pause the sender until every result has come back.
    wait_drained();

    idle_on = 1'b1;
    repeat (160) send_random_stick();

    // Final stretch at full rate, no idling on either side.
    idle_on = 1'b0;
    repeat (60) send_random_stick();

    wait_drained();
    repeat (40) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
